[rtl/assert_macros.svh]
// Assertion macros used by the checker module of the triplet merge block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define STMA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define STMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/stma_pkg.sv]
// Types, sizes and codes shared by the sparse triplet merge modules.
`default_nettype none

package stma_pkg;

   localparam int MAX_ENTRIES = 32;
   localparam int INDEX_BITS  = 8;

   localparam int KIND_W  = 2;
   localparam int FIELD_W = 8;
   localparam int VALUE_W = 32;

   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int KEY_W  = 2 * INDEX_BITS;

   localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
   localparam logic [KIND_W-1:0] KIND_START  = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [FIELD_W-1:0]        row_index;
      logic [FIELD_W-1:0]        col_index;
      logic signed [VALUE_W-1:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0]        out_row;
      logic [FIELD_W-1:0]        out_col;
      logic signed [VALUE_W-1:0] out_value;
      logic                      is_last;
      logic                      lost_entries;
   } rsp_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]     row;
      logic [INDEX_BITS-1:0]     col;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [CNT_W-1:0] count_a;
      logic [CNT_W-1:0] count_b;
      logic             overflow;
   } list_status_type;

   typedef struct packed {
      logic busy;
      logic clear;
   } merge_ctrl_type;

   typedef enum logic {
      MERGE_IDLE,
      MERGE_RUN
   } merge_state_type;

endpackage

`default_nettype wire

[rtl/stma_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module stma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/stma_loader.sv]
// Item decode, list fill counts, overflow flag and list write ports.
`default_nettype none

module stma_loader (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_fire,
   input  wire stma_pkg::req_type              req_item,
   input  wire stma_pkg::merge_ctrl_type       ctrl,
   output logic                                start,
   output logic                                wr_en_a,
   output logic                                wr_en_b,
   output logic [stma_pkg::ADDR_W-1:0]         wr_addr_a,
   output logic [stma_pkg::ADDR_W-1:0]         wr_addr_b,
   output stma_pkg::entry_type                 wr_entry,
   output stma_pkg::list_status_type           status
);

   import stma_pkg::*;

   logic [CNT_W-1:0] count_a_ff, count_a_in;
   logic [CNT_W-1:0] count_b_ff, count_b_in;
   logic             overflow_ff, overflow_in;
   logic             load_a, load_b;
   logic             full_a, full_b;

   assign full_a = (count_a_ff >= CNT_W'(MAX_ENTRIES));
   assign full_b = (count_b_ff >= CNT_W'(MAX_ENTRIES));

   always_comb begin
      load_a = 1'b0;
      load_b = 1'b0;
      start  = 1'b0;
      if (req_fire) begin
         unique case (req_item.kind)
            KIND_LOAD_A: load_a = 1'b1;
            KIND_LOAD_B: load_b = 1'b1;
            KIND_START:  start  = 1'b1;
            default:     ;
         endcase
      end
   end

   always_comb begin
      count_a_in  = count_a_ff;
      count_b_in  = count_b_ff;
      overflow_in = overflow_ff;
      if (ctrl.clear) begin
         count_a_in  = '0;
         count_b_in  = '0;
         overflow_in = 1'b0;
      end else begin
         if (load_a) begin
            if (full_a) begin
               overflow_in = 1'b1;
            end else begin
               count_a_in = count_a_ff + CNT_W'(1);
            end
         end
         if (load_b) begin
            if (full_b) begin
               overflow_in = 1'b1;
            end else begin
               count_b_in = count_b_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff  <= '0;
         count_b_ff  <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_a_ff  <= count_a_in;
         count_b_ff  <= count_b_in;
         overflow_ff <= overflow_in;
      end
   end

   assign wr_en_a         = load_a && !full_a;
   assign wr_en_b         = load_b && !full_b;
   assign wr_addr_a       = count_a_ff[ADDR_W-1:0];
   assign wr_addr_b       = count_b_ff[ADDR_W-1:0];
   assign wr_entry.row    = INDEX_BITS'(req_item.row_index);
   assign wr_entry.col    = INDEX_BITS'(req_item.col_index);
   assign wr_entry.value  = req_item.entry_value;
   assign status.count_a  = count_a_ff;
   assign status.count_b  = count_b_ff;
   assign status.overflow = overflow_ff;

endmodule

`default_nettype wire

[rtl/stma_merger.sv]
// Merge walker: list pointers, head compare, sum and the result register.
`default_nettype none

module stma_merger (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire stma_pkg::list_status_type      status,
   input  wire stma_pkg::entry_type            head_a,
   input  wire stma_pkg::entry_type            head_b,
   output logic [stma_pkg::ADDR_W-1:0]         rd_addr_a,
   output logic [stma_pkg::ADDR_W-1:0]         rd_addr_b,
   output stma_pkg::merge_ctrl_type            ctrl,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output stma_pkg::rsp_type                   rsp_item
);

   import stma_pkg::*;

   merge_state_type  state_ff, state_in;
   logic [CNT_W-1:0] ptr_a_ff, ptr_a_in;
   logic [CNT_W-1:0] ptr_b_ff, ptr_b_in;
   logic             lost_ff, lost_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_item_ff, rsp_item_in;
   logic             run;
   logic             live_a, live_b;
   logic             take_a, take_b;
   logic             fire;
   logic [KEY_W-1:0] key_a, key_b;

   assign live_a = (ptr_a_ff < status.count_a);
   assign live_b = (ptr_b_ff < status.count_b);
   assign key_a  = {head_a.row, head_a.col};
   assign key_b  = {head_b.row, head_b.col};
   assign take_a = live_a && (!live_b || (key_a <= key_b));
   assign take_b = live_b && (!live_a || (key_b <= key_a));
   assign fire   = run && (live_a || live_b) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MERGE_IDLE: begin
            if (start) begin
               state_in = MERGE_RUN;
            end
         end
         MERGE_RUN: begin
            if (!live_a && !live_b) begin
               state_in = MERGE_IDLE;
            end
         end
         default: state_in = MERGE_IDLE;
      endcase
   end

   always_comb begin
      run        = 1'b0;
      ctrl.busy  = 1'b0;
      ctrl.clear = 1'b0;
      unique case (state_ff)
         MERGE_IDLE: ;
         MERGE_RUN: begin
            run        = 1'b1;
            ctrl.busy  = 1'b1;
            ctrl.clear = !live_a && !live_b;
         end
         default: ;
      endcase
   end

   always_comb begin
      ptr_a_in = ptr_a_ff;
      ptr_b_in = ptr_b_ff;
      lost_in  = lost_ff;
      if (start) begin
         ptr_a_in = '0;
         ptr_b_in = '0;
         lost_in  = status.overflow;
      end else if (fire) begin
         ptr_a_in = ptr_a_ff + CNT_W'(take_a);
         ptr_b_in = ptr_b_ff + CNT_W'(take_b);
      end
   end

   assign rd_addr_a = ptr_a_in[ADDR_W-1:0];
   assign rd_addr_b = ptr_b_in[ADDR_W-1:0];

   always_comb begin
      rsp_item_in = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fire) begin
         rsp_valid_in             = 1'b1;
         rsp_item_in.out_row      = take_a ? FIELD_W'(head_a.row) : FIELD_W'(head_b.row);
         rsp_item_in.out_col      = take_a ? FIELD_W'(head_a.col) : FIELD_W'(head_b.col);
         rsp_item_in.out_value    = (take_a ? head_a.value : '0) +
                                    (take_b ? head_b.value : '0);
         rsp_item_in.is_last      = (ptr_a_in == status.count_a) &&
                                    (ptr_b_in == status.count_b);
         rsp_item_in.lost_entries = lost_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= MERGE_IDLE;
         ptr_a_ff     <= '0;
         ptr_b_ff     <= '0;
         lost_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_a_ff     <= ptr_a_in;
         ptr_b_ff     <= ptr_b_in;
         lost_ff      <= lost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

[rtl/sparse_triplet_merge_add.sv]
// Top level of the sparse matrix adder that merges two sorted triplet lists.
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_valid/req_ready    stma_pkg::req_type
//   rsp_      out         rsp_valid/rsp_ready    stma_pkg::rsp_type
//
// Load items may follow each other in every cycle while no merge runs.
// A start item runs a merge that gives one triplet per cycle while results are taken, since
// the merge walker reads one head from each list memory per cycle.
// The input is held off while a merge runs; a stalled result holds the walker in place.
// Reset empties both lists and clears the lost flag at once; the list memories are not cleared.
`default_nettype none

module sparse_triplet_merge_add (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire stma_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output stma_pkg::rsp_type      rsp_item
);

   import stma_pkg::*;

   merge_ctrl_type      ctrl;
   list_status_type     status;
   entry_type           wr_entry;
   logic [ENTRY_W-1:0]  head_a_raw, head_b_raw;
   logic [ADDR_W-1:0]   wr_addr_a, wr_addr_b;
   logic [ADDR_W-1:0]   rd_addr_a, rd_addr_b;
   logic                wr_en_a, wr_en_b;
   logic                start;
   logic                req_fire;

   assign req_ready = !ctrl.busy;
   assign req_fire  = req_valid && req_ready;

   stma_loader u_loader (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_item  (req_item),
      .ctrl      (ctrl),
      .start     (start),
      .wr_en_a   (wr_en_a),
      .wr_en_b   (wr_en_b),
      .wr_addr_a (wr_addr_a),
      .wr_addr_b (wr_addr_b),
      .wr_entry  (wr_entry),
      .status    (status)
   );

   stma_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_list_a (
      .clock   (clock),
      .wr_en   (wr_en_a),
      .wr_addr (wr_addr_a),
      .wr_data (wr_entry),
      .rd_addr (rd_addr_a),
      .rd_data (head_a_raw)
   );

   stma_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_list_b (
      .clock   (clock),
      .wr_en   (wr_en_b),
      .wr_addr (wr_addr_b),
      .wr_data (wr_entry),
      .rd_addr (rd_addr_b),
      .rd_data (head_b_raw)
   );

   stma_merger u_merger (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .head_a    (entry_type'(head_a_raw)),
      .head_b    (entry_type'(head_b_raw)),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .ctrl      (ctrl),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

[rtl/stma_checker.sv]
// Port-level assertions for the triplet merge block and their bind.
`default_nettype none
`include "assert_macros.svh"

module stma_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire stma_pkg::rsp_type rsp_item
);

   import stma_pkg::*;

   // A stalled result stays offered.
   `STMA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "stalled result item dropped")

   // Results only start while the input side is held off by a running merge.
   `STMA_ASSERT(a_rsp_in_merge, clock, reset, $rose(rsp_valid) |-> !$past(req_ready), "result item outside a merge")

   // A stalled result keeps its payload until it is taken.
   `STMA_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_item), "stalled result item changed")

   // The lost flag is the same on every triplet of one merge.
   `STMA_ASSERT_NEXT(a_lost_steady, clock, reset, rsp_valid && rsp_ready && !rsp_item.is_last, !rsp_valid || (rsp_item.lost_entries == $past(rsp_item.lost_entries)), "lost flag changed within a merge")

endmodule

bind sparse_triplet_merge_add stma_checker u_checker (.*);

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the sparse triplet merge adder: directed table, then random lists.
module tb_top;
   import stma_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 210;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 40;
   localparam int DIRECTED_COUNT = 22;

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type triplet;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{'{KIND_START,  8'h00, 8'h00, 32'h0000_0000}, 1'b0, '0},
      '{'{KIND_UNUSED, 8'h00, 8'h00, 32'h0000_0000}, 1'b0, '0},
      '{'{KIND_LOAD_A, 8'h00, 8'h00, 32'h7fff_ffff}, 1'b0, '0},
      '{'{KIND_LOAD_B, 8'h00, 8'h00, 32'h0000_0001}, 1'b0, '0},
      '{'{KIND_START,  8'h00, 8'h00, 32'h0000_0000}, 1'b1,
        '{8'h00, 8'h00, 32'h8000_0000, 1'b1, 1'b0}},
      '{'{KIND_LOAD_A, 8'hff, 8'hff, 32'h8000_0000}, 1'b0, '0},
      '{'{KIND_LOAD_B, 8'hff, 8'hff, 32'h8000_0000}, 1'b0, '0},
      '{'{KIND_START,  8'h00, 8'h00, 32'h0000_0000}, 1'b1,
        '{8'hff, 8'hff, 32'h0000_0000, 1'b1, 1'b0}},
      '{'{KIND_LOAD_A, 8'h00, 8'hff, 32'h0000_0000}, 1'b0, '0},
      '{'{KIND_START,  8'hff, 8'hff, 32'hffff_ffff}, 1'b1,
        '{8'h00, 8'hff, 32'h0000_0000, 1'b1, 1'b0}},
      '{'{KIND_LOAD_B, 8'hff, 8'h00, 32'hffff_ffff}, 1'b0, '0},
      '{'{KIND_START,  8'h00, 8'h00, 32'h0000_0000}, 1'b1,
        '{8'hff, 8'h00, 32'hffff_ffff, 1'b1, 1'b0}},
      '{'{KIND_LOAD_A, 8'h01, 8'h02, 32'd10}, 1'b0, '0},
      '{'{KIND_LOAD_A, 8'h01, 8'h01, 32'd20}, 1'b0, '0},
      '{'{KIND_LOAD_A, 8'h01, 8'h01, 32'd30}, 1'b0, '0},
      '{'{KIND_LOAD_B, 8'h01, 8'h01, 32'd5}, 1'b0, '0},
      '{'{KIND_LOAD_B, 8'h00, 8'hc8, 32'd7}, 1'b0, '0},
      '{'{KIND_UNUSED, 8'hff, 8'hff, 32'hffff_ffff}, 1'b0, '0},
      '{'{KIND_START,  8'h00, 8'h00, 32'h0000_0000}, 1'b0, '0},
      '{'{KIND_LOAD_B, 8'h03, 8'h04, 32'h5555_5555}, 1'b0, '0},
      '{'{KIND_LOAD_A, 8'h03, 8'h04, 32'haaaa_aaaa}, 1'b0, '0},
      '{'{KIND_START,  8'h00, 8'h00, 32'h0000_0000}, 1'b0, '0}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   entry_type shadow_a[$];
   entry_type shadow_b[$];
   logic      shadow_lost = 1'b0;
   rsp_type   expected_triplets[$];

   int  mismatch_count = 0;
   int  items_sent = 0;
   int  merges_sent = 0;
   int  triplets_checked = 0;
   int  cycle_count = 0;
   bit  sender_burst = 1'b0;
   bit  receiver_fast = 1'b0;

   sparse_triplet_merge_add dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   function automatic void track_item(input req_type item, input bit typed,
                                      input rsp_type given);
      entry_type        e;
      rsp_type          t;
      rsp_type          produced[$];
      int               ia;
      int               ib;
      logic [KEY_W-1:0] pos_a;
      logic [KEY_W-1:0] pos_b;
      e.row = item.row_index[INDEX_BITS-1:0];
      e.col = item.col_index[INDEX_BITS-1:0];
      e.value = item.entry_value;
      case (item.kind)
         KIND_LOAD_A: begin
            if (shadow_a.size() < MAX_ENTRIES) shadow_a.push_back(e);
            else shadow_lost = 1'b1;
         end
         KIND_LOAD_B: begin
            if (shadow_b.size() < MAX_ENTRIES) shadow_b.push_back(e);
            else shadow_lost = 1'b1;
         end
         KIND_START: begin
            ia = 0;
            ib = 0;
            while (ia < shadow_a.size() || ib < shadow_b.size()) begin
               if (ia < shadow_a.size() && ib < shadow_b.size()) begin
                  pos_a = {shadow_a[ia].row, shadow_a[ia].col};
                  pos_b = {shadow_b[ib].row, shadow_b[ib].col};
                  if (pos_a == pos_b) begin
                     e = shadow_a[ia];
                     e.value = e.value + shadow_b[ib].value;
                     ia++;
                     ib++;
                  end else if (pos_a < pos_b) begin
                     e = shadow_a[ia];
                     ia++;
                  end else begin
                     e = shadow_b[ib];
                     ib++;
                  end
               end else if (ia < shadow_a.size()) begin
                  e = shadow_a[ia];
                  ia++;
               end else begin
                  e = shadow_b[ib];
                  ib++;
               end
               t.out_row = e.row;
               t.out_col = e.col;
               t.out_value = e.value;
               t.is_last = 1'b0;
               t.lost_entries = shadow_lost;
               produced.push_back(t);
            end
            if (produced.size() > 0) produced[produced.size()-1].is_last = 1'b1;
            shadow_a.delete();
            shadow_b.delete();
            shadow_lost = 1'b0;
         end
         default: ;
      endcase
      if (typed) expected_triplets.push_back(given);
      else foreach (produced[k]) expected_triplets.push_back(produced[k]);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         1: return $signed($urandom_range(0, 7)) - 4;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input req_type item, input bit typed, input rsp_type given);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 16);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_item(item, typed, given);
      if (item.kind != KIND_UNUSED) items_sent++;
      if (item.kind == KIND_START) merges_sent++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_triplets.size() != 0) @(negedge clock);
   endtask

   task automatic send_matrix_pair(input int count_a, input int count_b);
      req_type loads[2][$];
      req_type item;
      req_type spare;
      int      counts[2];
      int      base_pos;
      int      pos_code;
      int      p;
      int      q;
      bit      dense;
      counts[0] = count_a;
      counts[1] = count_b;
      dense = $urandom_range(0, 1);
      base_pos = $urandom_range(0, 65535);
      sender_burst = ($urandom_range(0, 3) == 0);
      for (int side = 0; side < 2; side++) begin
         pos_code = base_pos + ((dense && side == 1) ? $urandom_range(0, 2) : 0);
         for (int n = 0; n < counts[side]; n++) begin
            item.kind = (side == 0) ? KIND_LOAD_A : KIND_LOAD_B;
            item.row_index = pos_code[15:8];
            item.col_index = pos_code[7:0];
            item.entry_value = pick_value();
            loads[side].push_back(item);
            if (dense) pos_code += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
            else pos_code += $urandom_range(1, 4000);
         end
         if ($urandom_range(0, 7) == 0 && loads[side].size() > 1) begin
            p = $urandom_range(0, loads[side].size() - 1);
            q = $urandom_range(0, loads[side].size() - 1);
            spare = loads[side][p];
            loads[side][p] = loads[side][q];
            loads[side][q] = spare;
         end
      end
      while (loads[0].size() + loads[1].size() > 0) begin
         if ($urandom_range(0, 15) == 0) begin
            item.kind = KIND_UNUSED;
            item.row_index = $urandom;
            item.col_index = $urandom;
            item.entry_value = $urandom;
            send_item(item, 1'b0, '0);
         end
         if (loads[1].size() == 0 || (loads[0].size() != 0 && $urandom_range(0, 1) == 1))
            item = loads[0].pop_front();
         else
            item = loads[1].pop_front();
         send_item(item, 1'b0, '0);
      end
      item.kind = KIND_START;
      item.row_index = $urandom;
      item.col_index = $urandom;
      item.entry_value = $urandom;
      send_item(item, 1'b0, '0);
   endtask

   task automatic check_triplet(input rsp_type got);
      rsp_type want;
      if (expected_triplets.size() == 0) begin
         report_mismatch($sformatf("unexpected triplet (%0d,%0d) value %0d",
                                   got.out_row, got.out_col, got.out_value));
         return;
      end
      want = expected_triplets.pop_front();
      if (got.out_row !== want.out_row)
         report_mismatch($sformatf("row %0d, expected %0d", got.out_row, want.out_row));
      if (got.out_col !== want.out_col)
         report_mismatch($sformatf("column %0d, expected %0d", got.out_col, want.out_col));
      if (got.out_value !== want.out_value)
         report_mismatch($sformatf("value %0d, expected %0d", got.out_value, want.out_value));
      if (got.is_last !== want.is_last)
         report_mismatch($sformatf("last flag %b, expected %b", got.is_last, want.is_last));
      if (got.lost_entries !== want.lost_entries)
         report_mismatch($sformatf("lost flag %b, expected %b",
                                   got.lost_entries, want.lost_entries));
      triplets_checked++;
   endtask

   initial begin
      int stall;
      while (reset) @(negedge clock);
      forever begin
         stall = receiver_fast ? 0 : $urandom_range(0, 16);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         check_triplet(rsp_item);
         if ($urandom_range(0, 15) == 0) receiver_fast = !receiver_fast;
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
   end

   initial begin
      int ca;
      int cb;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[r])
         send_item(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].triplet);
      wait_for_drain();

      send_matrix_pair(MAX_ENTRIES + 3, 4);
      send_matrix_pair(MAX_ENTRIES, MAX_ENTRIES);
      while (items_sent < ITEM_TARGET) begin
         ca = ($urandom_range(0, 9) == 0) ? $urandom_range(20, MAX_ENTRIES + 2)
                                          : $urandom_range(0, 8);
         cb = ($urandom_range(0, 9) == 0) ? $urandom_range(20, MAX_ENTRIES + 2)
                                          : $urandom_range(0, 8);
         send_matrix_pair(ca, cb);
         if ($urandom_range(0, 2) == 0) wait_for_drain();
      end

      wait_for_drain();
      repeat (2 * MAX_ENTRIES + 40) @(posedge clock);

      $display("Sent %0d load and start items in %0d merges; %0d triplets compared.",
               items_sent, merges_sent, triplets_checked);
      $display("Covered full and overflowing lists, wrapped and zero sums, unsorted lists.");
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
